/* design/lmcs_pkg.sv */
// ----------------------------------------------------------------------------
// lmcs_pkg
// Shared types and constants for the led matrix chain serializer.
// ----------------------------------------------------------------------------
package lmcs_pkg;

  localparam int ReqW  = 3;
  localparam int IdxW  = 4;
  localparam int CntW  = 4;
  localparam int DataW = 7;
  localparam int RowW  = 4;
  localparam int CfgW  = 16;
  localparam int RgbW  = 3;

  localparam logic [CfgW-1:0]  CfgReset  = 16'h0A40;
  localparam logic [DataW-1:0] CfgOnWord = 7'h77;

  typedef enum logic [ReqW-1:0] {
    REQ_PIXEL    = 3'd0,
    REQ_CONFIG   = 3'd1,
    REQ_CONTROL  = 3'd2,
    REQ_FRAME    = 3'd3,
    REQ_LINE_END = 3'd4
  } req_e;

  localparam logic [RgbW-1:0] Palette [16][16] = '{
    '{3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
    '{3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
    '{3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7},
    '{3'd1,3'd0,3'd0,3'd1,3'd0,3'd0,3'd1,3'd1,3'd1,3'd1,3'd0,3'd1,3'd1,3'd0,3'd1,3'd1},
    '{3'd2,3'd0,3'd2,3'd2,3'd0,3'd2,3'd0,3'd2,3'd1,3'd7,3'd4,3'd6,3'd0,3'd7,3'd7,3'd6},
    '{3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4},
    '{3'd3,3'd3,3'd0,3'd3,3'd0,3'd3,3'd0,3'd0,3'd3,3'd0,3'd3,3'd0,3'd3,3'd3,3'd0,3'd0},
    '{3'd5,3'd5,3'd7,3'd7,3'd5,3'd5,3'd5,3'd5,3'd5,3'd5,3'd5,3'd7,3'd5,3'd7,3'd5,3'd5},
    '{3'd6,3'd0,3'd0,3'd6,3'd0,3'd0,3'd6,3'd6,3'd6,3'd6,3'd0,3'd6,3'd6,3'd0,3'd6,3'd6},
    '{3'd1,3'd3,3'd3,3'd7,3'd3,3'd5,3'd3,3'd5,3'd3,3'd1,3'd3,3'd7,3'd1,3'd3,3'd1,3'd1},
    '{3'd0,3'd4,3'd6,3'd6,3'd0,3'd1,3'd0,3'd4,3'd6,3'd7,3'd6,3'd6,3'd5,3'd1,3'd2,3'd1},
    '{3'd1,3'd7,3'd0,3'd6,3'd2,3'd2,3'd5,3'd0,3'd5,3'd2,3'd7,3'd7,3'd6,3'd2,3'd2,3'd4},
    '{3'd1,3'd3,3'd3,3'd7,3'd3,3'd5,3'd3,3'd5,3'd3,3'd1,3'd3,3'd7,3'd1,3'd3,3'd1,3'd1},
    '{3'd1,3'd1,3'd3,3'd1,3'd1,3'd3,3'd1,3'd1,3'd3,3'd3,3'd3,3'd1,3'd1,3'd3,3'd1,3'd3},
    '{3'd1,3'd7,3'd1,3'd1,3'd1,3'd7,3'd1,3'd7,3'd1,3'd1,3'd7,3'd7,3'd7,3'd7,3'd7,3'd7},
    '{3'd3,3'd1,3'd3,3'd1,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd1,3'd1,3'd3,3'd1,3'd1,3'd3}
  };

  typedef struct packed {
    logic start;
    logic gen;
  } lmcs_cmd_t;

  typedef struct packed {
    logic has_results;
    logic gen_last;
  } lmcs_sts_t;

endpackage

/* design/lmcs_in_if.sv */
// ----------------------------------------------------------------------------
// lmcs_in_if
// Request channel: one word per serializer request.
// ----------------------------------------------------------------------------
interface lmcs_in_if;
  import lmcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [ReqW-1:0]   req_type;
  logic [IdxW-1:0]   upper_index;
  logic [IdxW-1:0]   lower_index;
  logic              last_slot;
  logic [CntW-1:0]   pulse_count;

  modport source (
    output valid, req_type, upper_index, lower_index, last_slot, pulse_count,
    input  ready
  );

  modport sink (
    input  valid, req_type, upper_index, lower_index, last_slot, pulse_count,
    output ready
  );

endinterface

/* design/lmcs_out_if.sv */
// ----------------------------------------------------------------------------
// lmcs_out_if
// Result channel: one word per data clock pulse or row update.
// ----------------------------------------------------------------------------
interface lmcs_out_if;
  import lmcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [DataW-1:0]  port_data;
  logic              latch_enable;
  logic              clock_pulse;
  logic [RowW-1:0]   row_address;
  logic              last_result;

  modport source (
    output valid, port_data, latch_enable, clock_pulse, row_address, last_result,
    input  ready
  );

  modport sink (
    input  valid, port_data, latch_enable, clock_pulse, row_address, last_result,
    output ready
  );

endinterface

/* design/lmcs_dp.sv */
// ----------------------------------------------------------------------------
// lmcs_dp
// Datapath: request registers, word counter, scan state and output register.
// ----------------------------------------------------------------------------
module lmcs_dp #(
  parameter int SCAN_ROWS       = 11,
  parameter int BITS_PER_DRIVER = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lmcs_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic [lmcs_pkg::ReqW-1:0]  req_type_i,
  input  logic [lmcs_pkg::IdxW-1:0]  upper_index_i,
  input  logic [lmcs_pkg::IdxW-1:0]  lower_index_i,
  input  logic                       last_slot_i,
  input  logic [lmcs_pkg::CntW-1:0]  pulse_count_i,
  input  lmcs_pkg::lmcs_cmd_t        cmd_i,
  output lmcs_pkg::lmcs_sts_t        sts_o,
  output logic [lmcs_pkg::DataW-1:0] port_data_o,
  output logic                       latch_enable_o,
  output logic                       clock_pulse_o,
  output logic [lmcs_pkg::RowW-1:0]  row_address_o,
  output logic                       last_result_o
);
  import lmcs_pkg::*;

  localparam logic [RowW-1:0] RowLast  = RowW'(SCAN_ROWS - 1);
  localparam logic [CntW-1:0] WordLast = CntW'(BITS_PER_DRIVER - 1);
  localparam logic [CntW-1:0] LatchLo  = CntW'(BITS_PER_DRIVER - 4);
  localparam logic [CntW-1:0] CfgTop   = CntW'(CfgW - 1);

  logic [CfgW-1:0]  cfg_q;
  logic [RowW-1:0]  row_q, row_d;
  logic             vsync_q;
  logic [DataW-1:0] held_q, held_d;

  req_e             type_q;
  logic [IdxW-1:0]  up_q, lo_q;
  logic             last_q;
  logic             vs_hit_q;
  logic [CntW-1:0]  cnt_q, last_idx_q, last_idx_d;

  logic [DataW-1:0] data_q, data_d;
  logic             le_q, le_d;
  logic             clk_q, clk_d;
  logic [RowW-1:0]  row_out_q, row_out_d;
  logic             lres_q;

  req_e             req_in;
  logic             vs_hit_in;
  logic             has_res;
  logic [RowW-1:0]  row_adv;

  assign req_in    = req_e'(req_type_i);
  assign vs_hit_in = vsync_q && (row_q == RowLast);
  assign row_adv   = (row_q >= RowLast) ? '0 : row_q + RowW'(1);

  // result count of the incoming request, as a last index
  always_comb begin
    has_res    = 1'b0;
    last_idx_d = '0;
    case (req_in)
      REQ_PIXEL, REQ_CONFIG: begin
        has_res    = 1'b1;
        last_idx_d = WordLast;
      end
      REQ_CONTROL: begin
        has_res    = (pulse_count_i != '0);
        last_idx_d = pulse_count_i - CntW'(1);
      end
      REQ_LINE_END: begin
        has_res    = 1'b1;
        last_idx_d = vs_hit_in ? CntW'(2) : '0;
      end
      default: begin
        has_res    = 1'b0;
        last_idx_d = '0;
      end
    endcase
  end

  // next result word
  always_comb begin
    data_d    = held_q;
    le_d      = 1'b0;
    clk_d     = 1'b1;
    row_out_d = row_q;
    held_d    = held_q;
    row_d     = row_q;
    case (type_q)
      REQ_PIXEL: begin
        data_d = {Palette[up_q][cnt_q], 1'b0, Palette[lo_q][cnt_q]};
        le_d   = last_q && (cnt_q == WordLast);
        held_d = data_d;
      end
      REQ_CONFIG: begin
        data_d = cfg_q[CfgTop - cnt_q] ? CfgOnWord : '0;
        le_d   = last_q && (cnt_q >= LatchLo);
        held_d = data_d;
      end
      REQ_CONTROL: begin
        le_d = 1'b1;
      end
      REQ_LINE_END: begin
        if (vs_hit_q && (cnt_q < CntW'(2))) begin
          le_d = 1'b1;
        end else begin
          clk_d     = 1'b0;
          row_d     = row_adv;
          row_out_d = row_adv;
        end
      end
      default: begin
        clk_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= CfgReset;
      row_q   <= '0;
      vsync_q <= 1'b0;
      held_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.start) begin
        if (req_in == REQ_FRAME) begin
          vsync_q <= 1'b1;
        end else if (req_in == REQ_LINE_END && vs_hit_in) begin
          vsync_q <= 1'b0;
        end
      end
      if (cmd_i.gen) begin
        row_q  <= row_d;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      type_q     <= req_in;
      up_q       <= upper_index_i;
      lo_q       <= lower_index_i;
      last_q     <= last_slot_i;
      vs_hit_q   <= vs_hit_in;
      last_idx_q <= last_idx_d;
      cnt_q      <= '0;
    end else if (cmd_i.gen) begin
      cnt_q <= cnt_q + CntW'(1);
    end
    if (cmd_i.gen) begin
      data_q    <= data_d;
      le_q      <= le_d;
      clk_q     <= clk_d;
      row_out_q <= row_out_d;
      lres_q    <= (cnt_q == last_idx_q);
    end
  end

  assign sts_o.has_results = has_res;
  assign sts_o.gen_last    = (cnt_q == last_idx_q);

  assign port_data_o    = data_q;
  assign latch_enable_o = le_q;
  assign clock_pulse_o  = clk_q;
  assign row_address_o  = row_out_q;
  assign last_result_o  = lres_q;

endmodule

/* design/lmcs_ctrl.sv */
// ----------------------------------------------------------------------------
// lmcs_ctrl
// Controller: request handshake, word sequencing and output valid.
// ----------------------------------------------------------------------------
module lmcs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  lmcs_pkg::lmcs_sts_t sts_i,
  output lmcs_pkg::lmcs_cmd_t cmd_o
);
  import lmcs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   start, gen;

  assign in_ready_o = (state_q == ST_IDLE);
  assign start      = in_valid_i && in_ready_o;
  assign gen        = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start && sts_i.has_results) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (gen && sts_i.gen_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (gen) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.start = start;
  assign cmd_o.gen   = gen;
  assign out_valid_o = out_valid_q;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen && sts_i.gen_last |=> state_q == ST_IDLE && out_valid_q)
    else $error("last word did not end the request");

  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !sts_i.has_results |=> state_q == ST_IDLE)
    else $error("request without words left idle");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && out_valid_q && !out_ready_i |=> state_q == ST_RUN && out_valid_q)
    else $error("stalled word lost");

endmodule

/* design/led_matrix_chain_serializer.sv */
// ----------------------------------------------------------------------------
// led_matrix_chain_serializer
// Serializes pixel, config, control and scan requests for a chain of led
// shift-register drivers, one clocked word per cycle unless stalled.
//
//   channel  dir  handshake        payload
//   in_i     in   valid / ready    req_type upper_index lower_index last_slot
//                                  pulse_count
//   out_o    out  valid / ready    port_data latch_enable clock_pulse
//                                  row_address last_result
//   cfg      in   cfg_we_i         cfg_wdata_i (config word)
//
// a request is taken while idle, then its words leave one per cycle while the
// output is not stalled, from the word counter: BITS_PER_DRIVER words for a
// pixel or config slot, pulse_count for a control command, 3 or 1 for a line
// end, none for a frame complete. reset gives idle, config word 0x0A40, row,
// vsync and held data zero. a stalled output word holds and the counter waits.
// ----------------------------------------------------------------------------
module led_matrix_chain_serializer #(
  parameter int SCAN_ROWS       = 11,
  parameter int BITS_PER_DRIVER = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lmcs_pkg::CfgW-1:0] cfg_wdata_i,
  lmcs_in_if.sink                   in_i,
  lmcs_out_if.source                out_o
);
  import lmcs_pkg::*;

  lmcs_cmd_t cmd;
  lmcs_sts_t sts;

  lmcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lmcs_dp #(
    .SCAN_ROWS       (SCAN_ROWS),
    .BITS_PER_DRIVER (BITS_PER_DRIVER)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (in_i.req_type),
    .upper_index_i  (in_i.upper_index),
    .lower_index_i  (in_i.lower_index),
    .last_slot_i    (in_i.last_slot),
    .pulse_count_i  (in_i.pulse_count),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .port_data_o    (out_o.port_data),
    .latch_enable_o (out_o.latch_enable),
    .clock_pulse_o  (out_o.clock_pulse),
    .row_address_o  (out_o.row_address),
    .last_result_o  (out_o.last_result)
  );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the led matrix chain serializer. Requests go in with
// random bursts and gaps while the output side stalls on a rolling pattern.
// A scoreboard class predicts every clocked word from the request stream and
// the config word, and checks each accepted word in order. The run covers a
// directed pass through all request kinds, then random phases under several
// config words.
// ----------------------------------------------------------------------------
module testbench;
  import lmcs_pkg::*;

  localparam int ScanRows      = 11;
  localparam int BitsPerDriver = 16;
  localparam int PhaseItems    = 40;
  localparam int Phases        = 8;
  localparam int DrainCycles   = 20;
  localparam int ShowLimit     = 10;

  localparam logic [ReqW-1:0] ReqUnusedFirst = ReqW'(REQ_LINE_END + 1);
  localparam logic [ReqW-1:0] ReqUnusedLast  = '1;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             latch;
    logic             pulse;
    logic [RowW-1:0]  row;
    logic             last;
  } word_t;

  class chain_scoreboard;
    word_t            pending_words[$];
    logic [CfgW-1:0]  cfg_word;
    logic [RowW-1:0]  scan_row;
    logic             vsync_armed;
    logic [DataW-1:0] held_data;
    int               failures;

    function new();
      cfg_word    = CfgReset;
      scan_row    = '0;
      vsync_armed = 1'b0;
      held_data   = '0;
      failures    = 0;
    endfunction

    function word_t make_word(logic [DataW-1:0] data, logic latch, logic pulse);
      word_t w;
      w.data  = data;
      w.latch = latch;
      w.pulse = pulse;
      w.row   = scan_row;
      w.last  = 1'b0;
      return w;
    endfunction

    function void note_request(logic [ReqW-1:0] req, logic [IdxW-1:0] up,
                               logic [IdxW-1:0] lo, logic last_slot,
                               logic [CntW-1:0] pulses);
      word_t words[$];
      logic [DataW-1:0] data;
      case (req)
        REQ_PIXEL: begin
          for (int i = 0; i < BitsPerDriver; i++) begin
            data = {Palette[up][i], 1'b0, Palette[lo][i]};
            held_data = data;
            words.push_back(make_word(data, last_slot && i == BitsPerDriver - 1, 1'b1));
          end
        end
        REQ_CONFIG: begin
          for (int i = 0; i < BitsPerDriver; i++) begin
            data = cfg_word[CfgW-1-i] ? CfgOnWord : '0;
            held_data = data;
            words.push_back(make_word(data, last_slot && i >= BitsPerDriver - 4, 1'b1));
          end
        end
        REQ_CONTROL: begin
          for (int i = 0; i < int'(pulses); i++)
            words.push_back(make_word(held_data, 1'b1, 1'b1));
        end
        REQ_FRAME: begin
          vsync_armed = 1'b1;
        end
        REQ_LINE_END: begin
          if (vsync_armed && scan_row == RowW'(ScanRows - 1)) begin
            words.push_back(make_word(held_data, 1'b1, 1'b1));
            words.push_back(make_word(held_data, 1'b1, 1'b1));
            vsync_armed = 1'b0;
          end
          if (scan_row >= RowW'(ScanRows - 1))
            scan_row = '0;
          else
            scan_row = scan_row + 1'b1;
          words.push_back(make_word(held_data, 1'b0, 1'b0));
        end
        default: begin
        end
      endcase
      if (words.size() > 0)
        words[words.size()-1].last = 1'b1;
      foreach (words[k])
        pending_words.push_back(words[k]);
    endfunction

    function void check_word(word_t got);
      word_t exp_w;
      if (pending_words.size() == 0) begin
        failures++;
        if (failures <= ShowLimit)
          $display("unexpected word: data=%h le=%b clk=%b row=%0d last=%b",
                   got.data, got.latch, got.pulse, got.row, got.last);
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.data !== exp_w.data || got.latch !== exp_w.latch ||
          got.pulse !== exp_w.pulse || got.row !== exp_w.row ||
          got.last !== exp_w.last) begin
        failures++;
        if (failures <= ShowLimit)
          $display({"mismatch: expected data=%h le=%b clk=%b row=%0d last=%b,",
                    " got data=%h le=%b clk=%b row=%0d last=%b"},
                   exp_w.data, exp_w.latch, exp_w.pulse, exp_w.row, exp_w.last,
                   got.data, got.latch, got.pulse, got.row, got.last);
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  lmcs_in_if  in_if ();
  lmcs_out_if out_if ();

  led_matrix_chain_serializer #(
    .SCAN_ROWS      (ScanRows),
    .BITS_PER_DRIVER(BitsPerDriver)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  chain_scoreboard sb = new();

  int          burst_left = 0;
  int          pat_pos = 0;
  logic [31:0] stall_pat = '1;

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (pat_pos == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat = '1;
        1:       stall_pat = $urandom | $urandom;
        2:       stall_pat = $urandom;
        default: stall_pat = ($urandom & $urandom) | 32'd1;
      endcase
    end
    out_if.ready = stall_pat[pat_pos];
    pat_pos = (pat_pos + 1) % 32;
  end

  always @(posedge clk_i) begin
    word_t got;
    if (rst_ni) begin
      if (cfg_we_i)
        sb.cfg_word = cfg_wdata_i;
      if (in_if.valid && in_if.ready)
        sb.note_request(in_if.req_type, in_if.upper_index, in_if.lower_index,
                        in_if.last_slot, in_if.pulse_count);
      if (out_if.valid && out_if.ready) begin
        got.data  = out_if.port_data;
        got.latch = out_if.latch_enable;
        got.pulse = out_if.clock_pulse;
        got.row   = out_if.row_address;
        got.last  = out_if.last_result;
        sb.check_word(got);
      end
    end
  end

  task automatic send_request(logic [ReqW-1:0] req, logic [IdxW-1:0] up,
                              logic [IdxW-1:0] lo, logic last_slot,
                              logic [CntW-1:0] pulses);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid       = 1'b1;
    in_if.req_type    = req;
    in_if.upper_index = up;
    in_if.lower_index = lo;
    in_if.last_slot   = last_slot;
    in_if.pulse_count = pulses;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (sb.pending_words.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_config(logic [CfgW-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic run_random(int count);
    int sent;
    int pick;
    logic [ReqW-1:0] req;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      req = REQ_PIXEL;
      else if (pick < 50) req = REQ_CONFIG;
      else if (pick < 68) req = REQ_CONTROL;
      else if (pick < 76) req = REQ_FRAME;
      else if (pick < 95) req = REQ_LINE_END;
      else                req = ReqW'($urandom_range(ReqUnusedFirst, ReqUnusedLast));
      send_request(req, IdxW'($urandom), IdxW'($urandom), 1'($urandom),
                   CntW'($urandom));
      if (req <= REQ_LINE_END)
        sent++;
    end
  endtask

  initial begin
    logic [CfgW-1:0] cfg_values[Phases];
    cfg_values = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001,
                   CfgW'($urandom), CfgW'($urandom), CfgReset, CfgW'($urandom)};
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_if.valid       = 1'b0;
    in_if.req_type    = REQ_PIXEL;
    in_if.upper_index = '0;
    in_if.lower_index = '0;
    in_if.last_slot   = 1'b0;
    in_if.pulse_count = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset config word first, then every request kind and its edges
    send_request(REQ_CONFIG, '0, '0, 1'b0, '0);
    send_request(REQ_CONFIG, '1, '1, 1'b1, '1);
    send_request(REQ_PIXEL, '0, '1, 1'b0, '0);
    send_request(REQ_PIXEL, '1, '0, 1'b1, '1);
    send_request(REQ_PIXEL, 4'd2, 4'd2, 1'b1, '0);
    send_request(REQ_CONTROL, '0, '0, 1'b0, 4'd1);
    send_request(REQ_CONTROL, '1, '1, 1'b1, '1);
    send_request(REQ_CONTROL, '0, '0, 1'b0, '0);
    send_request(ReqUnusedFirst, '1, '1, 1'b1, '1);
    send_request(ReqUnusedFirst + 1'b1, '0, '0, 1'b0, '0);
    send_request(ReqUnusedLast, '1, '0, 1'b1, 4'd5);
    // vsync armed at row zero, fires only once the row reaches the top
    send_request(REQ_FRAME, '0, '0, 1'b0, '0);
    repeat (ScanRows) send_request(REQ_LINE_END, '0, '0, 1'b0, '0);

    for (int p = 0; p < Phases; p++) begin
      wait_idle();
      write_config(cfg_values[p]);
      run_random(PhaseItems);
    end

    in_if.valid = 1'b0;
    while (sb.pending_words.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.pending_words.size() != 0) begin
      $display("%0d expected words never arrived", sb.pending_words.size());
      sb.failures++;
    end
    if (sb.failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
design/lmcs_pkg.sv
design/lmcs_in_if.sv
design/lmcs_out_if.sv
design/lmcs_dp.sv
design/lmcs_ctrl.sv
design/led_matrix_chain_serializer.sv
bench/testbench.sv
